// ===== sv/dpfh_pkg.sv =====
package dpfh_pkg;

   localparam int TempW = 15;
   localparam int RhW   = 14;
   localparam int DewW  = 16;

   // first divider: temperature term, second divider: final inversion
   localparam int Q1W = 22;
   localparam int D1W = 26;
   localparam int Q2W = 17;
   localparam int D2W = 37;
   localparam int LuW = 21;
   localparam int SW  = 23;

   localparam logic [RhW-1:0]         RhLimit    = 14'd10000;
   localparam logic signed [DewW-1:0] DewInvalid = -16'sd32767;
   localparam logic signed [DewW-1:0] DewMax     = 16'sd10000;

   localparam logic [17:0] KWarmNum  = 18'd175043;
   localparam logic [16:0] KTempOff  = 17'd24120;
   localparam logic [9:0]  KDenScale = 10'd625;
   localparam logic [15:0] KLn2      = 16'd45426;
   localparam logic [22:0] KLn10000  = 23'd603609;
   localparam logic [28:0] C3mWarm   = 29'd241200000;
   localparam logic [28:0] C3mCold   = 29'd272186000;
   localparam logic [38:0] C2nWarm   = 39'd11471618048;
   localparam logic [38:0] C2nCold   = 39'd14708441088;
   localparam logic [13:0] KSScale   = 14'd10000;

   typedef struct packed {
      logic                  bad;
      logic                  neg;
      logic signed [LuW-1:0] lu;
   } dpfh_side1_type;

   typedef struct packed {
      logic bad;
      logic neg_s;
      logic den_bad;
   } dpfh_side2_type;

   // ln(1+k/16) in q16
   function automatic logic [15:0] ln_base(input logic [3:0] idx);
      logic [15:0] v;
      case (idx)
         4'd0:  v = 16'd0;
         4'd1:  v = 16'd3973;
         4'd2:  v = 16'd7719;
         4'd3:  v = 16'd11262;
         4'd4:  v = 16'd14624;
         4'd5:  v = 16'd17821;
         4'd6:  v = 16'd20870;
         4'd7:  v = 16'd23783;
         4'd8:  v = 16'd26573;
         4'd9:  v = 16'd29248;
         4'd10: v = 16'd31818;
         4'd11: v = 16'd34292;
         4'd12: v = 16'd36675;
         4'd13: v = 16'd38975;
         4'd14: v = 16'd41196;
         4'd15: v = 16'd43345;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

   // difference to the next table entry
   function automatic logic [11:0] ln_step(input logic [3:0] idx);
      logic [11:0] v;
      case (idx)
         4'd0:  v = 12'd3973;
         4'd1:  v = 12'd3746;
         4'd2:  v = 12'd3543;
         4'd3:  v = 12'd3362;
         4'd4:  v = 12'd3197;
         4'd5:  v = 12'd3049;
         4'd6:  v = 12'd2913;
         4'd7:  v = 12'd2790;
         4'd8:  v = 12'd2675;
         4'd9:  v = 12'd2570;
         4'd10: v = 12'd2474;
         4'd11: v = 12'd2383;
         4'd12: v = 12'd2300;
         4'd13: v = 12'd2221;
         4'd14: v = 12'd2149;
         4'd15: v = 12'd2081;
         default: v = 12'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== sv/dpfh_if.sv =====
interface dpfh_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [dpfh_pkg::TempW-1:0]     air_temperature;
   logic                                  temperature_missing;
   logic [dpfh_pkg::RhW-1:0]              relative_humidity;

   modport source (output valid, output air_temperature, output temperature_missing,
                   output relative_humidity, input ready);
   modport sink (input valid, input air_temperature, input temperature_missing,
                 input relative_humidity, output ready);
endinterface

interface dpfh_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [dpfh_pkg::DewW-1:0]  dew_point;
   logic                              result_valid;

   modport source (output valid, output dew_point, output result_valid, input ready);
   modport sink (input valid, input dew_point, input result_valid, output ready);
endinterface

// ===== sv/dpfh_div.sv =====
module dpfh_div #(
   parameter int DW = dpfh_pkg::D1W,
   parameter int QW = dpfh_pkg::Q1W,
   parameter int SW = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             in_valid,
   input  logic [DW+QW-1:0] num,
   input  logic [DW-1:0]    den,
   input  logic [SW-1:0]    side_in,
   output logic             out_valid,
   output logic [QW-1:0]    quot,
   output logic             ovf,
   output logic [SW-1:0]    side_out
);

   localparam int NW = DW + QW;

   logic [DW-1:0] rem_ff  [QW];
   logic [QW-1:0] x_ff    [QW];
   logic [DW-1:0] d_ff    [QW];
   logic [SW-1:0] side_ff [QW];
   logic          ovf_ff  [QW];
   logic          v_ff    [QW];

   // one quotient bit per stage, restoring
   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [DW-1:0] rem_p;
      logic [QW-1:0] x_p;
      logic [DW-1:0] d_p;
      logic [SW-1:0] side_p;
      logic          ovf_p;
      logic          v_p;
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          ge;
      logic [DW-1:0] rem_in;
      logic [QW-1:0] x_in;

      if (k == 0) begin : g_first
         assign rem_p  = num[NW-1:QW];
         assign x_p    = num[QW-1:0];
         assign d_p    = den;
         assign side_p = side_in;
         assign ovf_p  = (num[NW-1:QW] >= den);
         assign v_p    = in_valid;
      end else begin : g_next
         assign rem_p  = rem_ff[k-1];
         assign x_p    = x_ff[k-1];
         assign d_p    = d_ff[k-1];
         assign side_p = side_ff[k-1];
         assign ovf_p  = ovf_ff[k-1];
         assign v_p    = v_ff[k-1];
      end

      always_comb begin
         trial  = {rem_p, x_p[QW-1]};
         diff   = trial - {1'b0, d_p};
         ge     = (trial >= {1'b0, d_p});
         rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
         x_in   = {x_p[QW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (enable) begin
            v_ff[k] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= rem_in;
            x_ff[k]    <= x_in;
            d_ff[k]    <= d_p;
            side_ff[k] <= side_p;
            ovf_ff[k]  <= ovf_p;
         end
      end
   end

   assign out_valid = v_ff[QW-1];
   assign quot      = x_ff[QW-1];
   assign ovf       = ovf_ff[QW-1];
   assign side_out  = side_ff[QW-1];

endmodule

// ===== sv/dpfh_ln.sv =====
module dpfh_ln (
   input  logic                              clock,
   input  logic                              enable,
   input  logic [dpfh_pkg::RhW-1:0]          rh,
   output logic signed [dpfh_pkg::LuW-1:0]   lu
);

   logic [3:0]  e_in;
   logic [29:0] wide;
   logic [3:0]  e_ff;
   logic [3:0]  idx_ff;
   logic [11:0] r_ff;

   logic [3:0]  eb_ff;
   logic [15:0] base_ff;
   logic [23:0] prod_ff;
   logic [23:0] prod_in;

   logic [21:0]        sum;
   logic [23:0]        rnd;
   logic signed [22:0] lu_w;

   // leading one gives the exponent, the rest is the mantissa
   always_comb begin
      e_in = '0;
      for (int i = 1; i < dpfh_pkg::RhW; i++) begin
         if (rh[i]) begin
            e_in = 4'(i);
         end
      end
      wide = {rh, 16'd0} >> e_in;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         e_ff   <= e_in;
         idx_ff <= wide[15:12];
         r_ff   <= wide[11:0];
      end
   end

   assign prod_in = 24'(dpfh_pkg::ln_step(idx_ff)) * 24'(r_ff);

   always_ff @(posedge clock) begin
      if (enable) begin
         eb_ff   <= e_ff;
         base_ff <= dpfh_pkg::ln_base(idx_ff);
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      rnd  = prod_ff + 24'd2048;
      sum  = 22'(eb_ff) * 22'(dpfh_pkg::KLn2) + 22'(base_ff) + 22'(rnd[23:12]);
      lu_w = $signed({1'b0, sum}) - $signed(dpfh_pkg::KLn10000);
      lu   = lu_w[dpfh_pkg::LuW-1:0];
   end

endmodule

// ===== sv/dew_point_from_humidity_core.sv =====
// requests pass stages 1-3, divider 1, stages 4-6, divider 2, output register
// throughput: one request per cycle; the pipeline holds while a result waits
// two pipelined restoring dividers (22 and 17 stages) set the depth
// synchronous active-high reset clears all valid bits; in-flight data is lost
// data registers are not reset
module dew_point_from_humidity_core (
   input logic        clock,
   input logic        reset,
   dpfh_req_if.sink   req,
   dpfh_rsp_if.source rsp
);

   logic adv;

   // stage 1
   logic        v1_ff, bad1_ff, neg1_ff;
   logic [14:0] tabs1_ff;
   logic [15:0] dsum1_ff;
   logic [dpfh_pkg::RhW-1:0] rh1_ff;
   logic signed [16:0] tw;
   logic [14:0] tabs_in;
   logic        bad_in;

   // stage 2
   logic        v2_ff, bad2_ff, neg2_ff;
   logic [31:0] prod2_ff;
   logic [24:0] d2_ff;

   // stage 3
   logic        v3_ff, bad3_ff, neg3_ff;
   logic [dpfh_pkg::D1W+dpfh_pkg::Q1W-1:0] n3_ff;
   logic [dpfh_pkg::D1W-1:0] dd3_ff;
   logic signed [dpfh_pkg::LuW-1:0] lu;
   dpfh_pkg::dpfh_side1_type side1_in, side1_out;

   // divider 1 output
   logic                     q1_valid;
   logic [dpfh_pkg::Q1W-1:0] q1;
   logic [dpfh_pkg::SW-1:0]  side1_bits;

   // stage 4
   logic v4_ff, bad4_ff, neg4_ff;
   logic signed [dpfh_pkg::SW-1:0] s4_ff, a4, s4_in;

   // stage 5
   logic v5_ff, bad5_ff, sneg5_ff;
   logic [49:0] p5_ff;
   logic signed [38:0] den5_ff, den5_in;
   logic [21:0] smag;

   // stage 6
   logic v6_ff;
   logic [dpfh_pkg::D2W+dpfh_pkg::Q2W-1:0] n6_ff;
   logic [dpfh_pkg::D2W-1:0] dd6_ff;
   dpfh_pkg::dpfh_side2_type side6_ff, side2_out;
   logic den_bad;

   // divider 2 output
   logic                     q2_valid;
   logic [dpfh_pkg::Q2W-1:0] q2;
   logic                     ovf2;
   logic [2:0]               side2_bits;

   // output register
   logic out_v_ff, rv_ff;
   logic signed [dpfh_pkg::DewW-1:0] dew_ff, dew_in;

   assign adv       = !out_v_ff || rsp.ready;
   assign req.ready = adv;

   always_comb begin
      tw      = 17'(req.air_temperature) + $signed(dpfh_pkg::KTempOff);
      tabs_in = req.air_temperature[14] ? 15'(-req.air_temperature) : req.air_temperature;
      bad_in  = req.temperature_missing || (req.relative_humidity == '0) ||
                (req.relative_humidity >= dpfh_pkg::RhLimit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= q1_valid;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         out_v_ff <= q2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bad1_ff  <= bad_in;
         neg1_ff  <= req.air_temperature[14];
         tabs1_ff <= tabs_in;
         dsum1_ff <= tw[15:0];
         rh1_ff   <= req.relative_humidity;

         bad2_ff  <= bad1_ff;
         neg2_ff  <= neg1_ff;
         prod2_ff <= 32'(tabs1_ff) * 32'(dpfh_pkg::KWarmNum);
         d2_ff    <= 25'(dsum1_ff) * 25'(dpfh_pkg::KDenScale);

         // 2n + d over 2d gives round half away from zero
         bad3_ff  <= bad2_ff;
         neg3_ff  <= neg2_ff;
         n3_ff    <= ((dpfh_pkg::D1W+dpfh_pkg::Q1W)'(prod2_ff) << 13) +
                     (dpfh_pkg::D1W+dpfh_pkg::Q1W)'(d2_ff);
         dd3_ff   <= {d2_ff, 1'b0};

         bad4_ff  <= side1_out.bad;
         neg4_ff  <= side1_out.neg;
         s4_ff    <= s4_in;

         bad5_ff  <= bad4_ff;
         sneg5_ff <= s4_ff[dpfh_pkg::SW-1];
         p5_ff    <= 50'(smag) * 50'(neg4_ff ? dpfh_pkg::C3mCold : dpfh_pkg::C3mWarm);
         den5_ff  <= den5_in;

         n6_ff    <= ((dpfh_pkg::D2W+dpfh_pkg::Q2W)'(p5_ff) << 1) +
                     (dpfh_pkg::D2W+dpfh_pkg::Q2W)'(den5_ff);
         dd6_ff   <= dpfh_pkg::D2W'(den5_ff << 1);
         side6_ff <= '{bad: bad5_ff, neg_s: sneg5_ff, den_bad: den_bad};

         rv_ff    <= !side2_out.bad;
         dew_ff   <= dew_in;
      end
   end

   dpfh_ln u_ln (
      .clock  (clock),
      .enable (adv),
      .rh     (rh1_ff),
      .lu     (lu)
   );

   assign side1_in = '{bad: bad3_ff, neg: neg3_ff, lu: lu};

   dpfh_div #(
      .DW (dpfh_pkg::D1W),
      .QW (dpfh_pkg::Q1W),
      .SW ($bits(dpfh_pkg::dpfh_side1_type))
   ) u_div_gamma (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (v3_ff),
      .num       (n3_ff),
      .den       (dd3_ff),
      .side_in   (side1_in),
      .out_valid (q1_valid),
      .quot      (q1),
      .ovf       (),
      .side_out  (side1_bits)
   );

   assign side1_out = dpfh_pkg::dpfh_side1_type'(side1_bits);

   always_comb begin
      a4    = side1_out.neg ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
      s4_in = a4 + dpfh_pkg::SW'(side1_out.lu);
      smag  = s4_ff[dpfh_pkg::SW-1] ? 22'(-s4_ff) : 22'(s4_ff);
      den5_in = $signed(neg4_ff ? dpfh_pkg::C2nCold : dpfh_pkg::C2nWarm) -
                39'(s4_ff) * $signed({25'd0, dpfh_pkg::KSScale});
      den_bad = den5_ff[38] || (den5_ff == '0);
   end

   dpfh_div #(
      .DW (dpfh_pkg::D2W),
      .QW (dpfh_pkg::Q2W),
      .SW ($bits(dpfh_pkg::dpfh_side2_type))
   ) u_div_dew (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (v6_ff),
      .num       (n6_ff),
      .den       (dd6_ff),
      .side_in   (side6_ff),
      .out_valid (q2_valid),
      .quot      (q2),
      .ovf       (ovf2),
      .side_out  (side2_bits)
   );

   assign side2_out = dpfh_pkg::dpfh_side2_type'(side2_bits);

   // saturate to the output range; bad inputs give the invalid code
   always_comb begin
      if (side2_out.bad) begin
         dew_in = dpfh_pkg::DewInvalid;
      end else if (side2_out.den_bad) begin
         dew_in = dpfh_pkg::DewMax;
      end else if (!side2_out.neg_s) begin
         if (ovf2 || (q2 > 17'd10000)) begin
            dew_in = dpfh_pkg::DewMax;
         end else begin
            dew_in = $signed(16'(q2));
         end
      end else begin
         if (ovf2 || (q2 > 17'd32767)) begin
            dew_in = dpfh_pkg::DewInvalid;
         end else begin
            dew_in = -$signed(16'(q2));
         end
      end
   end

   assign rsp.valid        = out_v_ff;
   assign rsp.dew_point    = dew_ff;
   assign rsp.result_valid = rv_ff;

endmodule

// ===== sv/dpfh_checker.sv =====
module dpfh_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [dpfh_pkg::DewW-1:0]  rsp_dew_point,
   input logic                              rsp_result_valid
);

   // nothing can come out straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_invalid_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_result_valid) |-> (rsp_dew_point == dpfh_pkg::DewInvalid))
      else $error("invalid response without invalid code");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_dew_point <= dpfh_pkg::DewMax) &&
                    (rsp_dew_point >= dpfh_pkg::DewInvalid))
      else $error("dew point outside saturation range");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_dew_point) &&
                                    $stable(rsp_result_valid))
      else $error("stalled response changed");

endmodule

bind dew_point_from_humidity_core dpfh_checker u_dpfh_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_dew_point    (rsp.dew_point),
   .rsp_result_valid (rsp.result_valid)
);

// ===== bench/dew_point_from_humidity_core_tb.sv =====
`timescale 1ns / 100ps

module dew_point_from_humidity_core_tb;

   typedef struct packed {
      logic signed [dpfh_pkg::DewW-1:0] dew_point;
      logic                             result_valid;
   } dew_result_type;

   localparam int WatchdogLimit = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dpfh_req_if req ();
   dpfh_rsp_if rsp ();

   dew_point_from_humidity_core DUT (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   always #6 clock = ~clock;

   dew_result_type dew_queue[$];
   int          mismatch_count = 0;
   int          result_count = 0;
   int          invalid_count = 0;
   int          saturated_count = 0;
   int          idle_cycles = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;

   // ln(1+k/16) in q16
   function automatic longint ln_point(input int k);
      longint pts[17] = '{0, 3973, 7719, 11262, 14624, 17821, 20870, 23783, 26573,
                          29248, 31818, 34292, 36675, 38975, 41196, 43345, 45426};
      return pts[k];
   endfunction

   function automatic longint round_div(input longint n, input longint d);
      if (n >= 0) begin
         return (n + d / 2) / d;
      end
      return -((-n + d / 2) / d);
   endfunction

   function automatic longint humidity_log(input logic [dpfh_pkg::RhW-1:0] x);
      int          e;
      logic [31:0] fr;
      int          i;
      longint      r;
      e = 13;
      while (e > 0 && x[e] == 1'b0) e--;
      fr = ({18'd0, x} << (16 - e)) & 32'hFFFF;
      i = fr[15:12];
      r = fr[11:0];
      return longint'(e) * 45426 + ln_point(i)
             + (((ln_point(i + 1) - ln_point(i)) * r + 2048) >>> 12);
   endfunction

   function automatic dew_result_type dew_point_of(
         input logic signed [dpfh_pkg::TempW-1:0] temp,
         input logic missing,
         input logic [dpfh_pkg::RhW-1:0] rh);
      dew_result_type res;
      longint      t;
      longint      a;
      longint      s;
      longint      c2;
      longint      c3;
      longint      den;
      longint      dew;
      t = temp;
      if (missing || rh == 0 || rh >= 10000) begin
         res.dew_point = -16'sd32767;
         res.result_valid = 1'b0;
         return res;
      end
      a = round_div(175043 * t * 65536, 10000 * (24120 + t));
      s = a + humidity_log(rh) - 603609;
      c2 = (t >= 0) ? 175043 : 224433;
      c3 = (t >= 0) ? 241200 : 272186;
      den = c2 * 65536 - 10000 * s;
      if (den <= 0) begin
         dew = 10000;
      end else begin
         dew = round_div(c3 * 1000 * s, den);
         if (dew > 10000) dew = 10000;
         if (dew < -32767) dew = -32767;
      end
      res.dew_point = dew[dpfh_pkg::DewW-1:0];
      res.result_valid = 1'b1;
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin
      dew_result_type got;
      dew_result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         got.dew_point = rsp.dew_point;
         got.result_valid = rsp.result_valid;
         result_count++;
         if (!got.result_valid) invalid_count++;
         if (got.dew_point == 16'sd10000) saturated_count++;
         if (dew_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected result %0d", got.dew_point));
         end else begin
            want = dew_queue.pop_front();
            if (got.dew_point !== want.dew_point)
               report_mismatch($sformatf("dew_point %0d, expected %0d",
                                         got.dew_point, want.dew_point));
            if (got.result_valid !== want.result_valid)
               report_mismatch($sformatf("result_valid %0b, expected %0b",
                                         got.result_valid, want.result_valid));
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("watchdog expired");
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   task automatic send_request(input logic signed [dpfh_pkg::TempW-1:0] temp,
                               input logic missing,
                               input logic [dpfh_pkg::RhW-1:0] rh);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.air_temperature <= temp;
      req.temperature_missing <= missing;
      req.relative_humidity <= rh;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      dew_queue.push_back(dew_point_of(temp, missing, rh));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (dew_queue.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      logic signed [dpfh_pkg::TempW-1:0] temps[8] = '{15'sd0, 15'sd1, -15'sd1, 15'sd10000,
                                           -15'sd10000, 15'sd16383, -15'sd16384, 15'sd2500};
      logic [dpfh_pkg::RhW-1:0] hums[6] = '{14'd1, 14'd9999, 14'd5000, 14'd100, 14'd4096,
                                            14'd8191};
      foreach (temps[k]) send_request(temps[k], 1'b0, hums[k % 6]);
      send_request(15'sd2000, 1'b0, 14'd0);
      send_request(15'sd2000, 1'b0, 14'd10000);
      send_request(15'sd2000, 1'b0, 14'd16383);
      send_request(15'sd2000, 1'b1, 14'd5000);
      send_request(-15'sd500, 1'b1, 14'd0);
      send_request(15'sd16383, 1'b0, 14'd9999);
      send_request(-15'sd16384, 1'b0, 14'd1);
      // pause until the pipeline is empty
      wait_drained();
      send_request(15'sd0, 1'b0, 14'd9999);
   endtask

   task automatic test_random(input int count);
      logic signed [dpfh_pkg::TempW-1:0] temp;
      logic [dpfh_pkg::RhW-1:0]          rh;
      logic                              missing;
      repeat (count) begin
         case ($urandom_range(9))
            0: temp = dpfh_pkg::TempW'($urandom);
            1: temp = dpfh_pkg::TempW'($urandom_range(200) - 100);
            default: temp = dpfh_pkg::TempW'($urandom_range(20000) - 10000);
         endcase
         case ($urandom_range(19))
            0: rh = dpfh_pkg::RhW'($urandom);
            1: rh = dpfh_pkg::RhW'($urandom_range(16383, 10000));
            default: rh = dpfh_pkg::RhW'($urandom_range(9999, 1));
         endcase
         missing = ($urandom_range(19) == 0);
         send_request(temp, missing, rh);
      end
   endtask

   initial begin
      req.valid = 1'b0;
      req.air_temperature = '0;
      req.temperature_missing = 1'b0;
      req.relative_humidity = '0;
      rsp.ready = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 29;
      recv_idle_pct = 48;
      test_directed();
      test_random(230);
      send_idle_pct = 48;
      recv_idle_pct = 29;
      test_random(230);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(240);
      wait_drained();
      repeat (60) @(negedge clock);
      $display("covered %0d results: %0d invalid, %0d at the upper bound",
               result_count, invalid_count, saturated_count);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/dpfh_pkg.sv
sv/dpfh_if.sv
sv/dpfh_div.sv
sv/dpfh_ln.sv
sv/dew_point_from_humidity_core.sv
sv/dpfh_checker.sv
bench/dew_point_from_humidity_core_tb.sv
